// ----- rtl/core/crm_pkg.sv -----
// Package for the call record / return matcher.
// Holds event codes, widths and the matching offsets; depends on nothing.
`timescale 1ns / 1ps

package crm_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned COUNT_W = 32;

  typedef enum logic {
    CMD_CALL   = 1'b0,
    CMD_RETURN = 1'b1
  } cmd_t;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam addr_t  OFFSET_LOW  = addr_t'(2);
  localparam addr_t  OFFSET_HIGH = addr_t'(7);
  localparam count_t TOTAL_MAX   = '1;

endpackage

// ----- rtl/core/crm_if.sv -----
// Valid/ready channel interfaces for the event and result transactions.
// Depends on crm_pkg for the payload types.
`timescale 1ns / 1ps

interface crm_event_if;
  import crm_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  addr_t addr;

  modport source (output valid, output cmd, output addr, input ready);
  modport sink (input valid, input cmd, input addr, output ready);
endinterface

interface crm_result_if;
  import crm_pkg::*;

  logic   valid;
  logic   ready;
  logic   matched;
  count_t match_count;
  logic   is_empty;

  modport source (output valid, output matched, output match_count, output is_empty,
                  input ready);
  modport sink (input valid, input matched, input match_count, input is_empty,
                output ready);
endinterface

// ----- rtl/core/call_record_return_matcher.sv -----
// Each accepted event transaction gives its result transaction, registered, in the next cycle.
// Throughput: one event per cycle while results are taken; events stall while an untaken result is held.
// The top entry is held in a register and the entry beneath it is read ahead from the
// record memory into a register, so consecutive returns do not wait on the memory.
// Reset empties the record and clears the match total; the memory is not cleared.
// Depends on crm_pkg and the channel interfaces in crm_if.sv.
`timescale 1ns / 1ps

module call_record_return_matcher #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  crm_event_if.sink     events,
  crm_result_if.source  results
);
  import crm_pkg::*;

  localparam int unsigned PW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  addr_t          mem [ENTRIES];
  logic [PW-1:0]  ptr, ptr_next, rd_addr;
  logic [CW-1:0]  count, count_next;
  count_t         total, total_next;
  addr_t          top_q, top_next, below_q, last, diff;
  logic           hit, fire;
  logic           out_valid, out_matched, out_empty;
  count_t         out_count;

  assign events.ready = !out_valid || results.ready;
  assign fire = events.valid && events.ready;

  assign last = (count != '0) ? top_q : '0;
  assign diff = events.addr - last;
  assign hit  = (events.cmd == CMD_RETURN) && (diff inside {[OFFSET_LOW:OFFSET_HIGH]});

  always_comb begin
    ptr_next   = ptr;
    count_next = count;
    top_next   = top_q;
    total_next = total;
    if (fire) begin
      if (events.cmd == CMD_CALL) begin
        ptr_next = (ptr == PW'(ENTRIES - 1)) ? '0 : ptr + 1'b1;
        top_next = events.addr;
        if (count != CW'(ENTRIES)) begin
          count_next = count + 1'b1;
        end
      end else begin
        if (hit && total != TOTAL_MAX) begin
          total_next = total + 1'b1;
        end
        if (count != '0) begin
          ptr_next   = (ptr == '0) ? PW'(ENTRIES - 1) : ptr - 1'b1;
          count_next = count - 1'b1;
          top_next   = below_q;
        end
      end
    end
    rd_addr = (ptr_next >= PW'(2)) ? ptr_next - PW'(2) : ptr_next + PW'(ENTRIES - 2);
  end

  always_ff @(posedge clk) begin
    if (fire && events.cmd == CMD_CALL) begin
      mem[ptr] <= events.addr;
    end
    below_q <= mem[rd_addr];
    top_q   <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      ptr   <= ptr_next;
      count <= count_next;
      total <= total_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_matched <= hit;
      out_count   <= total_next;
      out_empty   <= (count_next == '0);
    end
  end

  assign results.valid       = out_valid;
  assign results.matched     = out_matched;
  assign results.match_count = out_count;
  assign results.is_empty    = out_empty;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("Entry count exceeds the record depth.");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ptr < PW'(ENTRIES) || PW'(ENTRIES) == '0)
    else $error("Top pointer is outside the record.");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    fire && hit && total != TOTAL_MAX |=> total == $past(total) + 1'b1)
    else $error("Match total did not advance on a matching return.");

  a_call_result: assert property (@(posedge clk) disable iff (rst)
    fire && events.cmd == CMD_CALL |=> out_valid && !out_matched && !out_empty)
    else $error("A call transaction gave a match or an empty record.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !results.ready |=> $stable(total) && $stable(count))
    else $error("State changed while the result transaction was stalled.");

endmodule
